/* rtl/fl16_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fl16_pkg
// shared types, constants and the mod-255 add used by the record log scanner
// ----------------------------------------------------------------------------
package fl16_pkg;

    localparam int ADDR_W = 12;
    localparam int CNT_W  = 11;
    localparam int BYTE_W = 8;
    localparam int MOD    = 255;

    typedef enum logic [1:0] {
        PH_LOW,
        PH_HIGH,
        PH_BODY,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
    } t_result;

    // a below 255, b any byte: one conditional subtract keeps the sum below 255
    function automatic logic [BYTE_W-1:0] mod255_add(input logic [BYTE_W-1:0] a,
                                                     input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (BYTE_W+1)'(MOD)) begin
            s = s - (BYTE_W+1)'(MOD);
        end
        return s[BYTE_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/fl16_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fl16_cfg
// apb register holding the expected record version
// ----------------------------------------------------------------------------
module fl16_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [fl16_pkg::BYTE_W-1:0] o_version
);

    localparam logic [1:0] ADDR_VERSION = 2'b00;

    logic [fl16_pkg::BYTE_W-1:0] r_version;
    logic                        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr == ADDR_VERSION);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= '0;
        end else if (w_wr) begin
            r_version <= pwdata[fl16_pkg::BYTE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_VERSION) begin
            prdata = {{(32-fl16_pkg::BYTE_W){1'b0}}, r_version};
        end
    end

    assign o_version = r_version;

endmodule
`default_nettype wire

/* rtl/fl16_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fl16_scan
// per-byte scan engine: header parse, fletcher sums, record validation
// ----------------------------------------------------------------------------
module fl16_scan #(
    parameter int SECTOR_BYTES   = 4096,
    parameter int RECORD_BYTES   = 64,
    parameter int CHECK_OFFSET   = 62,
    parameter int VERSION_OFFSET = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic [fl16_pkg::BYTE_W-1:0] i_data,
    input  wire logic                        i_last,
    input  wire logic [fl16_pkg::BYTE_W-1:0] i_version,
    output fl16_pkg::t_result                o_res
);

    localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int AW    = fl16_pkg::ADDR_W;
    localparam int CW    = fl16_pkg::CNT_W;
    localparam int BW    = fl16_pkg::BYTE_W;

    fl16_pkg::t_phase r_phase, n_phase;
    logic [AW-1:0]    r_pos, n_pos;
    logic [BW-1:0]    r_hdr_lo, n_hdr_lo;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [BW-1:0]    r_sum_a, n_sum_a;
    logic [BW-1:0]    r_sum_b, n_sum_b;
    logic [2*BW-1:0]  r_chk, n_chk;
    logic [BW-1:0]    r_ver, n_ver;
    logic [AW-1:0]    r_start, n_start;
    logic [AW-1:0]    r_latest, n_latest;
    logic             r_found, n_found;
    logic [CW-1:0]    r_count, n_count;

    logic             w_hdr_fits;
    logic             w_size_ok;
    logic             w_body_end;
    logic             w_next_fits;
    logic [2*BW-1:0]  w_size;
    logic [BW-1:0]    w_sum_a;
    logic [BW-1:0]    w_sum_b;

    assign w_size      = {i_data, r_hdr_lo};
    assign w_hdr_fits  = (32'(r_pos) + 2) <= SECTOR_BYTES;
    assign w_size_ok   = (w_size == (2*BW)'(RECORD_BYTES))
                         && ((32'(r_start) + 2 + RECORD_BYTES) <= SECTOR_BYTES);
    assign w_body_end  = (32'(r_idx) + 1) >= RECORD_BYTES;
    assign w_next_fits = (32'(r_start) + 4 + RECORD_BYTES) <= SECTOR_BYTES;

    // running fletcher sums with this byte folded in
    assign w_sum_a = fl16_pkg::mod255_add(r_sum_a, i_data);
    assign w_sum_b = fl16_pkg::mod255_add(r_sum_b, w_sum_a);

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            fl16_pkg::PH_LOW: begin
                n_phase = w_hdr_fits ? fl16_pkg::PH_HIGH : fl16_pkg::PH_DONE;
            end
            fl16_pkg::PH_HIGH: begin
                n_phase = w_size_ok ? fl16_pkg::PH_BODY : fl16_pkg::PH_DONE;
            end
            fl16_pkg::PH_BODY: begin
                if (w_body_end) begin
                    n_phase = w_next_fits ? fl16_pkg::PH_LOW : fl16_pkg::PH_DONE;
                end
            end
            fl16_pkg::PH_DONE: begin
                n_phase = fl16_pkg::PH_DONE;
            end
            default: begin
                n_phase = fl16_pkg::PH_DONE;
            end
        endcase
    end

    // datapath updates
    always_comb begin
        n_pos    = r_pos;
        n_hdr_lo = r_hdr_lo;
        n_idx    = r_idx;
        n_sum_a  = r_sum_a;
        n_sum_b  = r_sum_b;
        n_chk    = r_chk;
        n_ver    = r_ver;
        n_start  = r_start;
        n_latest = r_latest;
        n_found  = r_found;
        n_count  = r_count;
        case (r_phase)
            fl16_pkg::PH_LOW: begin
                if (w_hdr_fits) begin
                    n_hdr_lo = i_data;
                    n_start  = r_pos;
                end
            end
            fl16_pkg::PH_HIGH: begin
                if (w_size_ok) begin
                    n_sum_a = '0;
                    n_sum_b = '0;
                    n_chk   = '0;
                    n_ver   = '0;
                    n_idx   = '0;
                end
            end
            fl16_pkg::PH_BODY: begin
                if (32'(r_idx) < CHECK_OFFSET) begin
                    n_sum_a = w_sum_a;
                    n_sum_b = w_sum_b;
                end
                if (32'(r_idx) == CHECK_OFFSET) begin
                    n_chk[BW-1:0] = i_data;
                end
                if (32'(r_idx) == CHECK_OFFSET + 1) begin
                    n_chk[2*BW-1:BW] = i_data;
                end
                if (32'(r_idx) == VERSION_OFFSET) begin
                    n_ver = i_data;
                end
                if (w_body_end) begin
                    n_count = r_count + CW'(1);
                    if ((n_ver == i_version) && (n_chk == {n_sum_b, n_sum_a})) begin
                        n_latest = r_start;
                        n_found  = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (r_phase != fl16_pkg::PH_DONE) begin
            n_pos = r_pos + AW'(1);
        end
    end

    // result as seen after this byte
    always_comb begin
        o_res.found = n_found;
        o_res.addr  = n_found ? n_latest : '0;
        o_res.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_phase  <= fl16_pkg::PH_LOW;
            r_pos    <= '0;
            r_hdr_lo <= '0;
            r_idx    <= '0;
            r_sum_a  <= '0;
            r_sum_b  <= '0;
            r_chk    <= '0;
            r_ver    <= '0;
            r_start  <= '0;
            r_latest <= '0;
            r_found  <= 1'b0;
            r_count  <= '0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_hdr_lo <= n_hdr_lo;
            r_idx    <= n_idx;
            r_sum_a  <= n_sum_a;
            r_sum_b  <= n_sum_b;
            r_chk    <= n_chk;
            r_ver    <= n_ver;
            r_start  <= n_start;
            r_latest <= n_latest;
            r_found  <= n_found;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

/* rtl/fletcher16_record_log_scanner.sv */
`default_nettype none
// result path: the result of an item marked last is loaded into the result register
//   (the input register feeds the scan logic straight into the result register)
// throughput: one sector byte per cycle while no last byte waits; the scan state
//   update is a single step through two chained mod-255 adds and a 16-bit compare
// stalls: a last byte waits in the input register only while the previous report
//   is still held by a stalled receiver
// reset: synchronous, active low; clears scan state and the version register,
//   no clearing pass needed
// ----------------------------------------------------------------------------
// fletcher16_record_log_scanner
// scans a flash sector of length-prefixed records and reports the header
// address of the last record whose version and fletcher-16 checksum match
// ----------------------------------------------------------------------------
module fletcher16_record_log_scanner #(
    parameter int SECTOR_BYTES   = 4096,
    parameter int RECORD_BYTES   = 64,
    parameter int CHECK_OFFSET   = 62,
    parameter int VERSION_OFFSET = 0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // byte stream in
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    // result out
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_found,
    output logic [11:0]      o_record_addr,
    output logic [10:0]      o_records_checked
);

    logic [7:0]        w_version;
    fl16_pkg::t_result w_res;

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_data;
    logic       r_in_last;

    // result register
    logic              r_out_vld;
    fl16_pkg::t_result r_out;

    logic w_in_acc;
    logic w_adv;

    fl16_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_version (w_version)
    );

    // a byte that gives no result always moves on; a last byte waits only
    // while the result register is full and stalled
    assign w_adv    = r_in_vld && (!r_in_last || !r_out_vld || !i_stall);
    assign o_stall  = r_in_vld && !w_adv;
    assign w_in_acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    // payload held while the item waits
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    fl16_scan #(
        .SECTOR_BYTES   (SECTOR_BYTES),
        .RECORD_BYTES   (RECORD_BYTES),
        .CHECK_OFFSET   (CHECK_OFFSET),
        .VERSION_OFFSET (VERSION_OFFSET)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_data    (r_in_data),
        .i_last    (r_in_last),
        .i_version (w_version),
        .o_res     (w_res)
    );

    // result register, loaded by the last byte of a sector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out <= w_res;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_found           = r_out.found;
    assign o_record_addr     = r_out.addr;
    assign o_records_checked = r_out.count;

endmodule
`default_nettype wire
